// ===== sv/chc_pkg.sv =====
// Shared constants, tables and helpers for the compass heading converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    // default build parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 16;

    // field widths
    localparam int RAW_W   = 16;
    localparam int FIELD_W = 24;
    localparam int GAIN_W  = 3;
    localparam int DECL_W  = 19;
    localparam int RAD_W   = 19;
    localparam int DEG_W   = 15;
    localparam int HEAD_W  = RAD_W + 1;   // signed heading before declination and wrap
    localparam int IN_W    = 48;
    localparam int OUT_W   = 112;

    // CORDIC datapath
    localparam int ATAN_LEN  = 24;
    localparam int PRESHIFT  = 24;
    localparam int CW        = 43;         // x/y width after preshift, with gain headroom
    localparam int OUT_FRAC  = 16;         // heading output is Q.16

    // pipeline bookkeeping
    localparam int LANE_CORE = 5;          // registers inside one scaling lane
    localparam int MERGE_PRE = 4;          // merge registers ahead of the output register

    // configuration register indexes
    localparam logic CFG_GAIN_SELECT = 1'b0;
    localparam logic CFG_DECLINATION = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 3'd6;

    // angle constants
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [RAD_W-1:0] PI_Q16     = RAD_W'((PI_Q30 + 64'd8192) >> 14);
    localparam logic [RAD_W-1:0] TWO_PI_Q16 = RAD_W'((64'd2 * PI_Q30 + 64'd8192) >> 14);

    // atan(2^-i) in Q.30, truncated
    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // field scaling: round(|raw| * 25600 / lsb) = floor((|raw| * 51200 + lsb) / (2 * lsb))
    localparam int LSB_W  = 11;
    localparam int DIV_W  = LSB_W + 1;
    localparam int RCP_W  = 24;
    localparam int RCP_SH = 32;
    localparam logic [15:0] UT_SCALE2 = 16'd51200;

    localparam logic [LSB_W-1:0] LSB_XY [7] = '{
        11'd1090, 11'd820, 11'd660, 11'd440, 11'd390, 11'd330, 11'd230
    };
    localparam logic [LSB_W-1:0] LSB_Z [7] = '{
        11'd980, 11'd760, 11'd600, 11'd400, 11'd255, 11'd295, 11'd205
    };
    // floor(2^32 / (2 * lsb))
    localparam logic [RCP_W-1:0] RCP_XY [7] = '{
        RCP_W'((64'd1 << RCP_SH) / 64'd2180), RCP_W'((64'd1 << RCP_SH) / 64'd1640),
        RCP_W'((64'd1 << RCP_SH) / 64'd1320), RCP_W'((64'd1 << RCP_SH) / 64'd880),
        RCP_W'((64'd1 << RCP_SH) / 64'd780),  RCP_W'((64'd1 << RCP_SH) / 64'd660),
        RCP_W'((64'd1 << RCP_SH) / 64'd460)
    };
    localparam logic [RCP_W-1:0] RCP_Z [7] = '{
        RCP_W'((64'd1 << RCP_SH) / 64'd1960), RCP_W'((64'd1 << RCP_SH) / 64'd1520),
        RCP_W'((64'd1 << RCP_SH) / 64'd1200), RCP_W'((64'd1 << RCP_SH) / 64'd800),
        RCP_W'((64'd1 << RCP_SH) / 64'd510),  RCP_W'((64'd1 << RCP_SH) / 64'd590),
        RCP_W'((64'd1 << RCP_SH) / 64'd410)
    };

    // degrees: round(h * 11520 * 16384 / PI_Q30), ties up
    localparam int T_W = 48;
    localparam int DEG_SH = 32;
    localparam logic [27:0] DEG_NUM  = 28'd188743680;
    localparam logic [31:0] DEG_HALF = 32'd1686629713;
    localparam logic [31:0] DEG_DEN  = 32'd3373259426;
    localparam logic [27:0] DEG_RCP  = 28'((64'd188743680 << DEG_SH) / 64'd3373259426);

    // Q.30 constant rounded to f fraction bits
    function automatic logic [63:0] q30_round(logic [63:0] c, int f);
        int s;
        s = 30 - f;
        return (c + (64'd1 << (s - 1))) >> s;
    endfunction

    // gain code seven behaves as six
    function automatic logic [GAIN_W-1:0] gain_sat(logic [GAIN_W-1:0] g);
        return (g > GAIN_MAX) ? GAIN_MAX : g;
    endfunction

endpackage

`default_nettype wire

// ===== sv/chc_scale_lane.sv =====
// One field scaling lane: signed count to 1/256 uT by reciprocal multiply
// and one remainder correction, padded to the heading path latency. Uses chc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chc_scale_lane #(
    parameter int DEPTH  = chc_pkg::CORDIC_STEPS_DEF + 2 + chc_pkg::MERGE_PRE,
    parameter bit Z_AXIS = 1'b0
) (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire signed [chc_pkg::RAW_W-1:0]      i_raw,
    input  wire        [chc_pkg::GAIN_W-1:0]     i_gain,
    output logic signed [chc_pkg::FIELD_W-1:0]   o_field
);

    localparam int NUM_W  = 31;
    localparam int PROD_W = NUM_W + chc_pkg::RCP_W;
    localparam int Q_W    = PROD_W - chc_pkg::RCP_SH;
    localparam int QD_W   = Q_W + chc_pkg::DIV_W;
    localparam int PAD    = DEPTH - chc_pkg::LANE_CORE;

    logic [chc_pkg::GAIN_W-1:0] gain;
    logic [chc_pkg::LSB_W-1:0]  lsb;
    logic [chc_pkg::RCP_W-1:0]  rcp;
    logic [chc_pkg::RAW_W:0]    mag;
    logic [NUM_W-1:0]           n_num;

    always_comb begin
        gain  = chc_pkg::gain_sat(i_gain);
        lsb   = Z_AXIS ? chc_pkg::LSB_Z[gain] : chc_pkg::LSB_XY[gain];
        rcp   = Z_AXIS ? chc_pkg::RCP_Z[gain] : chc_pkg::RCP_XY[gain];
        mag   = i_raw[chc_pkg::RAW_W-1] ? ((chc_pkg::RAW_W+1)'(0) - {i_raw[chc_pkg::RAW_W-1], i_raw})
                                        : {1'b0, i_raw};
        n_num = NUM_W'(mag) * NUM_W'(chc_pkg::UT_SCALE2) + NUM_W'(lsb);
    end

    logic [NUM_W-1:0]          r_num0, r_num1, r_num2, r_num3;
    logic [chc_pkg::DIV_W-1:0] r_div0, r_div1, r_div2, r_div3;
    logic                      r_neg0, r_neg1, r_neg2, r_neg3;
    logic [chc_pkg::RCP_W-1:0] r_rcp0;
    logic [PROD_W-1:0]         r_prod;
    logic [Q_W-1:0]            r_q2, r_q3;
    logic [QD_W-1:0]           r_qd;
    logic signed [chc_pkg::FIELD_W-1:0] r_field;

    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q_fix;

    always_comb begin
        rem   = r_num3 - r_qd[NUM_W-1:0];
        // estimate is at most one low
        q_fix = (rem >= NUM_W'(r_div3)) ? r_q3 + Q_W'(1) : r_q3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0  <= n_num;
            r_div0  <= {lsb, 1'b0};
            r_neg0  <= i_raw[chc_pkg::RAW_W-1];
            r_rcp0  <= rcp;

            r_prod  <= PROD_W'(r_num0) * PROD_W'(r_rcp0);
            r_num1  <= r_num0;
            r_div1  <= r_div0;
            r_neg1  <= r_neg0;

            r_q2    <= r_prod[PROD_W-1:chc_pkg::RCP_SH];
            r_num2  <= r_num1;
            r_div2  <= r_div1;
            r_neg2  <= r_neg1;

            r_qd    <= QD_W'(r_q2) * QD_W'(r_div2);
            r_q3    <= r_q2;
            r_num3  <= r_num2;
            r_div3  <= r_div2;
            r_neg3  <= r_neg2;

            r_field <= r_neg3 ? (chc_pkg::FIELD_W'(0) - chc_pkg::FIELD_W'(q_fix))
                              : chc_pkg::FIELD_W'(q_fix);
        end
    end

    generate
        if (PAD > 0) begin : g_pad
            logic signed [chc_pkg::FIELD_W-1:0] r_pad [PAD];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pad[0] <= r_field;
                    for (int k = 1; k < PAD; k++) begin
                        r_pad[k] <= r_pad[k-1];
                    end
                end
            end
            assign o_field = r_pad[PAD-1];
        end else begin : g_nopad
            assign o_field = r_field;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== sv/chc_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) of raw counts, one stage per step,
// result in signed Q.16 radians. Uses chc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chc_cordic #(
    parameter int STEPS = chc_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC  = chc_pkg::ANGLE_FRAC_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire signed [chc_pkg::RAW_W-1:0]     i_x,
    input  wire signed [chc_pkg::RAW_W-1:0]     i_y,
    output logic signed [chc_pkg::HEAD_W-1:0]   o_heading
);

    localparam int ZW  = FRAC + 4;
    localparam int XW  = chc_pkg::RAW_W + 1;
    localparam int EXW = ZW + chc_pkg::OUT_FRAC + 1;
    localparam logic signed [ZW-1:0] HALF_PI =
        ZW'(chc_pkg::q30_round(chc_pkg::HALF_PI_Q30, FRAC));

    // pre-rotation into the right half plane
    logic signed [XW-1:0]  x_e, y_e, px, py;
    logic signed [ZW-1:0]  n_z0;
    logic signed [chc_pkg::CW-1:0] x_w, y_w;

    always_comb begin
        x_e = {i_x[chc_pkg::RAW_W-1], i_x};
        y_e = {i_y[chc_pkg::RAW_W-1], i_y};
        px  = x_e;
        py  = y_e;
        n_z0 = '0;
        if (i_x[chc_pkg::RAW_W-1]) begin
            if (!i_y[chc_pkg::RAW_W-1] && (i_y != '0)) begin
                px   = y_e;
                py   = -x_e;
                n_z0 = HALF_PI;
            end else begin
                px   = -y_e;
                py   = x_e;
                n_z0 = -HALF_PI;
            end
        end
        x_w = {{(chc_pkg::CW-XW){px[XW-1]}}, px};
        y_w = {{(chc_pkg::CW-XW){py[XW-1]}}, py};
    end

    logic signed [chc_pkg::CW-1:0] r_x [STEPS+1];
    logic signed [chc_pkg::CW-1:0] r_y [STEPS+1];
    logic signed [ZW-1:0]          r_z [STEPS+1];
    logic [STEPS:0]                r_yz;   // y was zero: angle is exact
    logic [STEPS:0]                r_xn;   // x was negative

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= x_w <<< chc_pkg::PRESHIFT;
            r_y[0]  <= y_w <<< chc_pkg::PRESHIFT;
            r_z[0]  <= n_z0;
            r_yz[0] <= (i_y == '0);
            r_xn[0] <= i_x[chc_pkg::RAW_W-1];
            for (int i = 0; i < STEPS; i++) begin
                if (!r_y[i][chc_pkg::CW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ZW'(chc_pkg::q30_round(64'(chc_pkg::ATAN_Q30[i]), FRAC));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ZW'(chc_pkg::q30_round(64'(chc_pkg::ATAN_Q30[i]), FRAC));
                end
            end
            r_yz[STEPS:1] <= r_yz[STEPS-1:0];
            r_xn[STEPS:1] <= r_xn[STEPS-1:0];
        end
    end

    // convert the accumulated angle to Q.16
    logic signed [EXW-1:0] z_ext, z_q16;
    assign z_ext = {{(chc_pkg::OUT_FRAC+1){r_z[STEPS][ZW-1]}}, r_z[STEPS]};

    generate
        if (FRAC > chc_pkg::OUT_FRAC) begin : g_round
            localparam int SH = FRAC - chc_pkg::OUT_FRAC;
            localparam logic signed [EXW-1:0] RND = EXW'(1) <<< (SH - 1);
            assign z_q16 = (z_ext + RND) >>> SH;
        end else begin : g_widen
            assign z_q16 = z_ext <<< (chc_pkg::OUT_FRAC - FRAC);
        end
    endgenerate

    logic signed [chc_pkg::HEAD_W-1:0] n_heading;
    logic signed [chc_pkg::HEAD_W-1:0] r_heading;

    always_comb begin
        if (r_yz[STEPS]) begin
            n_heading = r_xn[STEPS] ? chc_pkg::HEAD_W'(chc_pkg::PI_Q16) : '0;
        end else begin
            n_heading = z_q16[chc_pkg::HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_heading <= n_heading;
        end
    end

    assign o_heading = r_heading;

endmodule

`default_nettype wire

// ===== sv/chc_merge.sv =====
// Merge stage: declination and wrap, heading to 1/64 degree, and the output
// register that packs the three lane fields with the heading. Uses chc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chc_merge (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire signed [chc_pkg::HEAD_W-1:0]     i_heading,
    input  wire signed [chc_pkg::DECL_W-1:0]     i_declination,
    input  wire signed [chc_pkg::FIELD_W-1:0]    i_field_x,
    input  wire signed [chc_pkg::FIELD_W-1:0]    i_field_y,
    input  wire signed [chc_pkg::FIELD_W-1:0]    i_field_z,
    output logic       [chc_pkg::OUT_W-1:0]      o_tdata
);

    localparam int SW  = chc_pkg::HEAD_W + 1;
    localparam int QW  = chc_pkg::T_W - chc_pkg::DEG_SH;
    localparam logic signed [SW-1:0] TWO_PI_S = SW'(chc_pkg::TWO_PI_Q16);
    localparam logic [chc_pkg::T_W-1:0] Q_RND  = chc_pkg::T_W'(1) << (chc_pkg::DEG_SH - 1);

    // add positive declination, wrap into 0..2pi
    logic signed [SW-1:0] d_pos, h_sum, n_h;

    always_comb begin
        d_pos = (!i_declination[chc_pkg::DECL_W-1] && (i_declination != '0))
              ? {{(SW-chc_pkg::DECL_W){1'b0}}, i_declination} : '0;
        h_sum = {i_heading[chc_pkg::HEAD_W-1], i_heading} + d_pos;
        priority if (h_sum[SW-1]) begin
            n_h = h_sum + TWO_PI_S;
        end else if (h_sum > TWO_PI_S) begin
            n_h = h_sum - TWO_PI_S;
        end else begin
            n_h = h_sum;
        end
    end

    logic [chc_pkg::RAD_W-1:0] r_h0, r_h1, r_h2, r_h3;
    logic [chc_pkg::T_W-1:0]   r_t1, r_t2, r_t3;
    logic [chc_pkg::T_W-1:0]   r_p1, r_qd3;
    logic [QW-1:0]             r_q2, r_q3;
    logic [chc_pkg::T_W-1:0]   q_sum, rem;
    logic [QW-1:0]             deg;
    logic [chc_pkg::OUT_W-1:0] r_tdata;

    always_comb begin
        q_sum = r_p1 + Q_RND;
        rem   = r_t3 - r_qd3;
        // reciprocal estimate is at most one low
        deg   = (rem >= chc_pkg::T_W'(chc_pkg::DEG_DEN)) ? r_q3 + QW'(1) : r_q3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0  <= n_h[chc_pkg::RAD_W-1:0];

            r_t1  <= chc_pkg::T_W'(r_h0) * chc_pkg::T_W'(chc_pkg::DEG_NUM)
                   + chc_pkg::T_W'(chc_pkg::DEG_HALF);
            r_p1  <= chc_pkg::T_W'(r_h0) * chc_pkg::T_W'(chc_pkg::DEG_RCP);
            r_h1  <= r_h0;

            r_q2  <= q_sum[chc_pkg::T_W-1:chc_pkg::DEG_SH];
            r_t2  <= r_t1;
            r_h2  <= r_h1;

            r_qd3 <= chc_pkg::T_W'(r_q2) * chc_pkg::T_W'(chc_pkg::DEG_DEN);
            r_q3  <= r_q2;
            r_t3  <= r_t2;
            r_h3  <= r_h2;

            r_tdata <= chc_pkg::OUT_W'({deg[chc_pkg::DEG_W-1:0], r_h3,
                                        i_field_z, i_field_y, i_field_x});
        end
    end

    assign o_tdata = r_tdata;

endmodule

`default_nettype wire

// ===== sv/compass_heading_converter.sv =====
// Top level of the compass heading converter: input register, three field
// scaling lanes, CORDIC heading lane and merge. Uses chc_pkg and all chc_ modules.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+---------------------------------
//  sample   | in        | s_axis_tvalid / s_axis_tready  | s_axis_tdata: six raw bytes
//  result   | out       | m_axis_tvalid / m_axis_tready  | m_axis_tdata: fields, heading
//  config   | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while results are taken; the CORDIC pipeline has one
// register stage per step. All stages advance together; while a result waits on
// m_axis_tready the pipeline holds and s_axis_tready drops. Bubbles pass through freely.
// Reset clears the valid pipeline and both configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_converter #(
    parameter int CORDIC_STEPS        = chc_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = chc_pkg::ANGLE_FRAC_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_low, x_high, y_low, y_high, z_low, z_high (8 bits each)
    input  wire  [chc_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // field_x[23:0], field_y[47:24], field_z[71:48], heading_radians[90:72],
    // heading_degrees[105:91], zero fill
    output logic [chc_pkg::OUT_W-1:0]        m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire                              i_cfg_index,
    input  wire  [chc_pkg::DECL_W-1:0]       i_cfg_data
);

    localparam int LANE_DEPTH = CORDIC_STEPS + 2 + chc_pkg::MERGE_PRE;
    localparam int PIPE_LEN   = LANE_DEPTH + 2;

    logic                               en;
    logic [PIPE_LEN-1:0]                r_vld;
    logic [chc_pkg::IN_W-1:0]           r_in_data;
    logic [chc_pkg::GAIN_W-1:0]         r_gain_select;
    logic signed [chc_pkg::DECL_W-1:0]  r_declination;

    assign en            = !r_vld[PIPE_LEN-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[PIPE_LEN-1];
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_select <= '0;
            r_declination <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                chc_pkg::CFG_GAIN_SELECT: begin
                    r_gain_select <= i_cfg_data[chc_pkg::GAIN_W-1:0];
                end
                chc_pkg::CFG_DECLINATION: begin
                    r_declination <= i_cfg_data;
                end
                default: begin
                    r_declination <= r_declination;
                end
            endcase
        end
    end

    logic signed [chc_pkg::RAW_W-1:0]   raw_x, raw_y, raw_z;
    logic signed [chc_pkg::FIELD_W-1:0] field_x, field_y, field_z;
    logic signed [chc_pkg::HEAD_W-1:0]  heading;

    assign raw_x = r_in_data[15:0];
    assign raw_y = r_in_data[31:16];
    assign raw_z = r_in_data[47:32];

    chc_scale_lane #(.DEPTH(LANE_DEPTH), .Z_AXIS(1'b0)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_raw   (raw_x),
        .i_gain  (r_gain_select),
        .o_field (field_x)
    );

    chc_scale_lane #(.DEPTH(LANE_DEPTH), .Z_AXIS(1'b0)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_raw   (raw_y),
        .i_gain  (r_gain_select),
        .o_field (field_y)
    );

    chc_scale_lane #(.DEPTH(LANE_DEPTH), .Z_AXIS(1'b1)) u_lane_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_raw   (raw_z),
        .i_gain  (r_gain_select),
        .o_field (field_z)
    );

    chc_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRACTION_BITS)) u_cordic (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_x       (raw_x),
        .i_y       (raw_y),
        .o_heading (heading)
    );

    chc_merge u_merge (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_heading     (heading),
        .i_declination (r_declination),
        .i_field_x     (field_x),
        .i_field_y     (field_y),
        .i_field_z     (field_z),
        .o_tdata       (m_axis_tdata)
    );

endmodule

`default_nettype wire
